@@ sv/assert_macros.svh @@
// Assertion macros shared by the equalizer RTL files.
// No dependencies; included by each module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge while reset is low.
`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// The condition must never be true at a rising edge while reset is low.
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) else $error(msg);

`endif

@@ sv/beq_pkg.sv @@
// Shared types and codes for the cascaded biquad equalizer.
// No dependencies; imported by every module of the block.
package beq_pkg;

  localparam int NCOEF   = 5;
  localparam int BAND_FW = 2;
  localparam int SEL_FW  = 3;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // Coefficient selects; the same codes number the taps of one section.
  localparam logic [SEL_FW-1:0] SEL_B0 = 3'd0;
  localparam logic [SEL_FW-1:0] SEL_B1 = 3'd1;
  localparam logic [SEL_FW-1:0] SEL_B2 = 3'd2;
  localparam logic [SEL_FW-1:0] SEL_A1 = 3'd3;
  localparam logic [SEL_FW-1:0] SEL_A2 = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_DRAIN,
    ST_ROUND,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic              start;
    logic              mul_en;
    logic [SEL_FW-1:0] tap;
    logic              rnd_en;
  } mac_ctrl_t;

  typedef struct packed {
    logic              shift_en;
    logic [SEL_FW-1:0] tap;
  } reg_ctrl_t;

endpackage

@@ sv/beq_regs.sv @@
// Coefficient store and per-band input/output history of the equalizer.
// Depends on beq_pkg for field widths, select codes and the control struct.
module beq_regs import beq_pkg::*; #(
  parameter int BANDS = 4,
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH = 32,
  localparam int BAND_IW = (BANDS > 1) ? $clog2(BANDS) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  reg_ctrl_t               ctrl,
  input  logic [BAND_IW-1:0]      band_idx,
  input  logic [SAMPLE_WIDTH-1:0] x_cur,
  input  logic [SAMPLE_WIDTH-1:0] y_new,
  input  logic                    wr_en,
  input  logic [BAND_FW-1:0]      wr_band,
  input  logic [SEL_FW-1:0]       wr_sel,
  input  logic [COEF_WIDTH-1:0]   wr_value,
  output logic [COEF_WIDTH-1:0]   coef_rd,
  output logic [SAMPLE_WIDTH-1:0] oper_rd
);

  localparam int F = COEF_WIDTH - 4;
  localparam logic [COEF_WIDTH-1:0] UNITY = {{(COEF_WIDTH-1){1'b0}}, 1'b1} << F;

  logic [COEF_WIDTH-1:0]   coef [BANDS][NCOEF];
  logic [SAMPLE_WIDTH-1:0] x1 [BANDS];
  logic [SAMPLE_WIDTH-1:0] x2 [BANDS];
  logic [SAMPLE_WIDTH-1:0] y1 [BANDS];
  logic [SAMPLE_WIDTH-1:0] y2 [BANDS];

  logic               wr_ok;
  logic [BAND_IW-1:0] wr_idx;

  // Writes to a band beyond the configured count or to an unused select are dropped.
  assign wr_ok  = wr_en && (int'(wr_band) < BANDS) && (int'(wr_sel) < NCOEF);
  assign wr_idx = BAND_IW'(wr_band);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BANDS; b++) begin
        for (int k = 0; k < NCOEF; k++) begin
          coef[b][k] <= (k == 0) ? UNITY : '0;
        end
        x1[b] <= '0;
        x2[b] <= '0;
        y1[b] <= '0;
        y2[b] <= '0;
      end
    end else if (wr_ok) begin
      coef[wr_idx][wr_sel] <= wr_value;
      x1[wr_idx] <= '0;
      x2[wr_idx] <= '0;
      y1[wr_idx] <= '0;
      y2[wr_idx] <= '0;
    end else if (ctrl.shift_en) begin
      x2[band_idx] <= x1[band_idx];
      x1[band_idx] <= x_cur;
      y2[band_idx] <= y1[band_idx];
      y1[band_idx] <= y_new;
    end
  end

  always_comb begin
    coef_rd = coef[band_idx][ctrl.tap];
    case (ctrl.tap)
      SEL_B0:  oper_rd = x_cur;
      SEL_B1:  oper_rd = x1[band_idx];
      SEL_B2:  oper_rd = x2[band_idx];
      SEL_A1:  oper_rd = y1[band_idx];
      SEL_A2:  oper_rd = y2[band_idx];
      default: oper_rd = '0;
    endcase
  end

endmodule

@@ sv/beq_mac.sv @@
// Shared multiply-accumulate unit with round-half-up and saturation.
// Depends on beq_pkg for the control struct and tap codes.
`include "assert_macros.svh"
module beq_mac import beq_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctrl_t               ctrl,
  input  logic [SAMPLE_WIDTH-1:0] sample_in,
  input  logic [COEF_WIDTH-1:0]   coef_rd,
  input  logic [SAMPLE_WIDTH-1:0] oper_rd,
  output logic [SAMPLE_WIDTH-1:0] y_new,
  output logic [SAMPLE_WIDTH-1:0] x_cur,
  output logic                    clip
);

  localparam int PW = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int AW = PW + 3;
  localparam int F  = COEF_WIDTH - 4;
  localparam int QW = AW - F;
  localparam logic signed [AW-1:0] ROUND_HALF = {{(AW-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic [SAMPLE_WIDTH-1:0] MAXV = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] MINV = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [PW-1:0] prod;
  logic                 p_valid;
  logic                 p_first;
  logic                 p_neg;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_next;
  logic signed [AW-1:0] addend;
  logic signed [AW-1:0] base;
  logic signed [AW-1:0] rnd;
  logic [QW-1:0]        q;
  logic                 in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      clip    <= 1'b0;
    end else begin
      p_valid <= ctrl.mul_en;
      if (ctrl.start) begin
        clip <= 1'b0;
      end else if (ctrl.rnd_en) begin
        clip <= clip | ~in_range;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod    <= $signed(coef_rd) * $signed(oper_rd);
      p_first <= (ctrl.tap == SEL_B0);
      p_neg   <= (ctrl.tap == SEL_A1) || (ctrl.tap == SEL_A2);
    end
    if (p_valid) begin
      acc <= acc_next;
    end
    if (ctrl.start) begin
      x_cur <= sample_in;
    end else if (ctrl.rnd_en) begin
      x_cur <= y_new;
    end
  end

  // The feedback taps enter with a minus sign; the first tap restarts the sum.
  always_comb begin
    addend   = AW'(prod);
    base     = p_first ? '0 : acc;
    acc_next = p_neg ? (base - addend) : (base + addend);
  end

  always_comb begin
    rnd      = acc + ROUND_HALF;
    q        = rnd[AW-1:F];
    in_range = (&q[QW-1:SAMPLE_WIDTH-1]) | ~(|q[QW-1:SAMPLE_WIDTH-1]);
    y_new    = in_range ? q[SAMPLE_WIDTH-1:0] : (q[QW-1] ? MINV : MAXV);
  end

  `ASSERT_NEVER(a_round_after_drain, clk, rst, ctrl.rnd_en && p_valid, "rounding with a product in flight")
  `ASSERT_NEVER(a_start_quiet, clk, rst, ctrl.start && (p_valid || ctrl.mul_en), "sample start while busy")

endmodule

@@ sv/beq_ctrl.sv @@
// Sequencer that walks taps and bands through the shared multiply-accumulate unit.
// Depends on beq_pkg for the state type, codes and control structs.
`include "assert_macros.svh"
module beq_ctrl import beq_pkg::*; #(
  parameter int BANDS = 4,
  localparam int BAND_IW = (BANDS > 1) ? $clog2(BANDS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_op,
  input  logic               out_free,
  output logic               in_ready,
  output mac_ctrl_t          mac_ctrl,
  output reg_ctrl_t          reg_ctrl,
  output logic [BAND_IW-1:0] band_idx,
  output logic               out_load
);

  localparam logic [BAND_IW-1:0] LAST_BAND = BAND_IW'(BANDS - 1);
  localparam logic [SEL_FW-1:0]  LAST_TAP  = SEL_A2;

  seq_state_t         state, state_next;
  logic [SEL_FW-1:0]  tap_cnt, tap_cnt_next;
  logic [BAND_IW-1:0] band_cnt, band_cnt_next;

  assign band_idx = band_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      tap_cnt  <= SEL_B0;
      band_cnt <= '0;
    end else begin
      state    <= state_next;
      tap_cnt  <= tap_cnt_next;
      band_cnt <= band_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    tap_cnt_next  = tap_cnt;
    band_cnt_next = band_cnt;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    mac_ctrl      = '0;
    reg_ctrl      = '0;
    mac_ctrl.tap  = tap_cnt;
    reg_ctrl.tap  = tap_cnt;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_op == OP_FILTER)) begin
          mac_ctrl.start = 1'b1;
          tap_cnt_next   = SEL_B0;
          band_cnt_next  = '0;
          state_next     = ST_TAP;
        end
      end
      ST_TAP: begin
        mac_ctrl.mul_en = 1'b1;
        if (tap_cnt == LAST_TAP) begin
          tap_cnt_next = SEL_B0;
          state_next   = ST_DRAIN;
        end else begin
          tap_cnt_next = tap_cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        mac_ctrl.rnd_en   = 1'b1;
        reg_ctrl.shift_en = 1'b1;
        if (band_cnt == LAST_BAND) begin
          state_next = ST_DONE;
        end else begin
          band_cnt_next = band_cnt + 1'b1;
          state_next    = ST_TAP;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_AT(a_tap_range, clk, rst, (state == ST_TAP) |-> (tap_cnt <= LAST_TAP), "tap count out of range")
  `ASSERT_AT(a_band_range, clk, rst, (state != ST_IDLE) |-> (band_cnt <= LAST_BAND), "band count out of range")

endmodule

@@ sv/four_band_biquad_equalizer_core.sv @@
// Top level of the cascaded biquad equalizer: stream ports and output register.
// Depends on beq_pkg, beq_ctrl, beq_regs and beq_mac.
//
//   channel   role    tdata (low bit up)                                tuser
//   s_axis    input   sample_in, band, coef_select, coef_value, zeros   operation
//   m_axis    output  sample_out, zeros                                 clipped
//
// In a filter beat one shared multiplier runs the five taps of each band, then
// the band passes through a drain state and a round state.
// A coefficient beat is taken while the sequencer is idle and clears that band's history.
// Synchronous reset sets every band to unity gain with zero history.
// A finished sample waits in the sequencer while the output register is full.
`include "assert_macros.svh"
module four_band_biquad_equalizer_core import beq_pkg::*; #(
  parameter int BANDS = 4,
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH = 32,
  localparam int IN_W = SAMPLE_WIDTH + BAND_FW + SEL_FW + COEF_WIDTH,
  localparam int IN_TW = ((IN_W + 7) / 8) * 8,
  localparam int OUT_TW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // sample_in, band, coef_select, coef_value, zero fill
  input  logic [IN_TW-1:0]  s_axis_tdata,
  // operation
  input  logic              s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // sample_out, zero fill
  output logic [OUT_TW-1:0] m_axis_tdata,
  // clipped
  output logic              m_axis_tuser
);

  localparam int BAND_LSB = SAMPLE_WIDTH;
  localparam int SEL_LSB  = BAND_LSB + BAND_FW;
  localparam int VAL_LSB  = SEL_LSB + SEL_FW;
  localparam int BAND_IW  = (BANDS > 1) ? $clog2(BANDS) : 1;

  mac_ctrl_t               mac_ctrl;
  reg_ctrl_t               reg_ctrl;
  logic [BAND_IW-1:0]      band_idx;
  logic                    out_load;
  logic                    out_free;
  logic                    wr_en;
  logic [COEF_WIDTH-1:0]   coef_rd;
  logic [SAMPLE_WIDTH-1:0] oper_rd;
  logic [SAMPLE_WIDTH-1:0] y_new;
  logic [SAMPLE_WIDTH-1:0] x_cur;
  logic                    clip;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign wr_en    = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_COEF);

  beq_ctrl #(
    .BANDS(BANDS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .out_free (out_free),
    .in_ready (s_axis_tready),
    .mac_ctrl (mac_ctrl),
    .reg_ctrl (reg_ctrl),
    .band_idx (band_idx),
    .out_load (out_load)
  );

  beq_regs #(
    .BANDS(BANDS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH(COEF_WIDTH)
  ) u_regs (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (reg_ctrl),
    .band_idx (band_idx),
    .x_cur    (x_cur),
    .y_new    (y_new),
    .wr_en    (wr_en),
    .wr_band  (s_axis_tdata[SEL_LSB-1:BAND_LSB]),
    .wr_sel   (s_axis_tdata[VAL_LSB-1:SEL_LSB]),
    .wr_value (s_axis_tdata[VAL_LSB+COEF_WIDTH-1:VAL_LSB]),
    .coef_rd  (coef_rd),
    .oper_rd  (oper_rd)
  );

  beq_mac #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH(COEF_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mac_ctrl),
    .sample_in (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .coef_rd   (coef_rd),
    .oper_rd   (oper_rd),
    .y_new     (y_new),
    .x_cur     (x_cur),
    .clip      (clip)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= OUT_TW'(x_cur);
      m_axis_tuser <= clip;
    end
  end

  `ASSERT_NEVER(a_no_overwrite, clk, rst, out_load && m_axis_tvalid && !m_axis_tready, "output beat overwritten")
  `ASSERT_NEVER(a_busy_not_ready, clk, rst, s_axis_tready && (mac_ctrl.mul_en || mac_ctrl.rnd_en), "ready while filtering")

endmodule
